// ===== sv/fwp_pkg.sv =====
// Package for the flux write precompensation block.
// Holds field widths, clamp limits, register indexes and the shared structs.
// No dependencies.
`default_nettype none
package fwp_pkg;

  localparam int unsigned MAX_CLASSES = 4;

  localparam int unsigned RUN_W     = 8;
  localparam int unsigned SAT_W     = 7;
  localparam int unsigned CLASS_W   = 2;
  localparam int unsigned NCLS_W    = 3;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned TIME_W    = 15;
  localparam int unsigned SHIFT_W   = 16;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned LEN_W     = 18;
  localparam int unsigned ADJ_W     = 19;
  localparam int unsigned CV_W      = 7;
  localparam int unsigned INV_W     = 16;
  localparam int unsigned ROW_W     = 64;
  localparam int unsigned NROWS     = 4;

  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 6;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [SAT_W-1:0]        RUN_SAT = 7'd127;
  localparam logic signed [ADJ_W-1:0] LEN_MIN = 19'sd768;
  localparam logic signed [ADJ_W-1:0] LEN_MAX = 19'sd32767;
  localparam logic [INV_W-1:0]        INV_FULL = 16'hffff;
  localparam logic [NCLS_W-1:0]       CLASSES_RESET = 3'd3;

  localparam logic [REG_IDX_W-1:0] REG_CLASSES_IN_USE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CLASS_COUNTS      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CLASS_WRITE_TIMES = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PRECOMP_ROW0      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PRECOMP_ROW1      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PRECOMP_ROW2      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PRECOMP_ROW3      = 3'd6;

  typedef struct packed {
    logic [NCLS_W-1:0]                classes_in_use;
    logic [MAX_CLASSES*COUNT_W-1:0]   class_counts;
    logic [MAX_CLASSES*TIME_W-1:0]    class_write_times;
    logic [NROWS-1:0][ROW_W-1:0]      precomp_rows;
  } fwp_cfg_t;

  // Classifier result for one pulse.
  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic               found;
    logic [TIME_W-1:0]  write_time;
  } fwp_class_t;

  // Precompensation result for the pending pulse.
  typedef struct packed {
    logic                    valid;
    logic [CV_W-1:0]         counter_value;
    logic                    clipped;
    logic signed [LEN_W-1:0] next_length;
  } fwp_pulse_t;

endpackage
`default_nettype wire

// ===== sv/fwp_if.sv =====
// Valid/ready stream interfaces for run counts in and pulse results out.
// Depends on fwp_pkg for the field widths.
`default_nettype none
interface fwp_in_if;
  logic                        valid;
  logic                        ready;
  logic [fwp_pkg::RUN_W-1:0]   run_count;

  modport source (output valid, output run_count, input ready);
  modport sink   (input valid, input run_count, output ready);
endinterface

interface fwp_out_if;
  logic                        valid;
  logic                        ready;
  logic [fwp_pkg::CV_W-1:0]    counter_value;
  logic                        clipped;
  logic                        pattern_invalid;
  logic [fwp_pkg::INV_W-1:0]   invalid_total;

  modport source (output valid, output counter_value, output clipped,
                  output pattern_invalid, output invalid_total, input ready);
  modport sink   (input valid, input counter_value, input clipped,
                  input pattern_invalid, input invalid_total, output ready);
endinterface
`default_nettype wire

// ===== sv/fwp_apb_regs.sv =====
// APB register file for the flux write precompensation block.
// Depends on fwp_pkg for register indexes and the configuration struct.
`default_nettype none
module fwp_apb_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fwp_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [fwp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [fwp_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output fwp_pkg::fwp_cfg_t                     cfg_o
);

  fwp_pkg::fwp_cfg_t                 cfg_q;
  logic [fwp_pkg::REG_IDX_W-1:0]     idx;
  logic                              wr_en;

  assign idx   = paddr[fwp_pkg::APB_ADDR_W-1:fwp_pkg::APB_ADDR_W-fwp_pkg::REG_IDX_W];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.classes_in_use    <= fwp_pkg::CLASSES_RESET;
      cfg_q.class_counts      <= '0;
      cfg_q.class_write_times <= '0;
      cfg_q.precomp_rows      <= '0;
    end else if (wr_en) begin
      unique case (idx)
        fwp_pkg::REG_CLASSES_IN_USE:
          cfg_q.classes_in_use <= pwdata[fwp_pkg::NCLS_W-1:0];
        fwp_pkg::REG_CLASS_COUNTS:
          cfg_q.class_counts <= pwdata[fwp_pkg::MAX_CLASSES*fwp_pkg::COUNT_W-1:0];
        fwp_pkg::REG_CLASS_WRITE_TIMES:
          cfg_q.class_write_times <= pwdata[fwp_pkg::MAX_CLASSES*fwp_pkg::TIME_W-1:0];
        fwp_pkg::REG_PRECOMP_ROW0: cfg_q.precomp_rows[0] <= pwdata;
        fwp_pkg::REG_PRECOMP_ROW1: cfg_q.precomp_rows[1] <= pwdata;
        fwp_pkg::REG_PRECOMP_ROW2: cfg_q.precomp_rows[2] <= pwdata;
        fwp_pkg::REG_PRECOMP_ROW3: cfg_q.precomp_rows[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fwp_pkg::REG_CLASSES_IN_USE:
        prdata = fwp_pkg::APB_DATA_W'(cfg_q.classes_in_use);
      fwp_pkg::REG_CLASS_COUNTS:
        prdata = fwp_pkg::APB_DATA_W'(cfg_q.class_counts);
      fwp_pkg::REG_CLASS_WRITE_TIMES:
        prdata = fwp_pkg::APB_DATA_W'(cfg_q.class_write_times);
      fwp_pkg::REG_PRECOMP_ROW0: prdata = cfg_q.precomp_rows[0];
      fwp_pkg::REG_PRECOMP_ROW1: prdata = cfg_q.precomp_rows[1];
      fwp_pkg::REG_PRECOMP_ROW2: prdata = cfg_q.precomp_rows[2];
      fwp_pkg::REG_PRECOMP_ROW3: prdata = cfg_q.precomp_rows[3];
      default:                   prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/fwp_classify.sv =====
// Pulse classifier: matches a saturated run count against the class counts.
// Depends on fwp_pkg for widths, the configuration struct and the result struct.
`default_nettype none
module fwp_classify (
  input  fwp_pkg::fwp_cfg_t              cfg_i,
  input  wire logic [fwp_pkg::SAT_W-1:0] run_i,
  output fwp_pkg::fwp_class_t            class_o
);

  logic [fwp_pkg::NCLS_W-1:0]  n_eff;
  logic [fwp_pkg::CLASS_W-1:0] cls;
  logic                        found;

  always_comb begin
    if (cfg_i.classes_in_use == '0) begin
      n_eff = fwp_pkg::NCLS_W'(1);
    end else if (cfg_i.classes_in_use > fwp_pkg::NCLS_W'(fwp_pkg::MAX_CLASSES)) begin
      n_eff = fwp_pkg::NCLS_W'(fwp_pkg::MAX_CLASSES);
    end else begin
      n_eff = cfg_i.classes_in_use;
    end

    // Highest matching class wins; no match falls back to the last class.
    cls   = fwp_pkg::CLASS_W'(n_eff - fwp_pkg::NCLS_W'(1));
    found = 1'b0;
    for (int c = 0; c < fwp_pkg::MAX_CLASSES; c++) begin
      if (fwp_pkg::NCLS_W'(c) < n_eff &&
          cfg_i.class_counts[fwp_pkg::COUNT_W*c +: fwp_pkg::COUNT_W] == run_i) begin
        cls   = fwp_pkg::CLASS_W'(c);
        found = 1'b1;
      end
    end
  end

  assign class_o.cls        = cls;
  assign class_o.found      = found;
  assign class_o.write_time = cfg_i.class_write_times[fwp_pkg::TIME_W*cls +: fwp_pkg::TIME_W];

endmodule
`default_nettype wire

// ===== sv/fwp_precomp.sv =====
// Precompensation shift, pulse update and clamp of the pending pulse.
// Depends on fwp_pkg for widths, clamp limits and the shared structs.
`default_nettype none
module fwp_precomp (
  input  fwp_pkg::fwp_cfg_t                       cfg_i,
  input  fwp_pkg::fwp_class_t                     class_i,
  input  wire logic [fwp_pkg::FRAC_W-1:0]         frac_i,
  input  wire logic signed [fwp_pkg::LEN_W-1:0]   pend_len_i,
  input  wire logic [fwp_pkg::CLASS_W-1:0]        pend_cls_i,
  output fwp_pkg::fwp_pulse_t                     pulse_o
);

  logic                              pend_pos;
  logic signed [fwp_pkg::SHIFT_W-1:0] sh;
  logic signed [fwp_pkg::ADJ_W-1:0]   sh_ext;
  logic signed [fwp_pkg::ADJ_W-1:0]   cur_base;
  logic signed [fwp_pkg::ADJ_W-1:0]   cur_adj;
  logic signed [fwp_pkg::ADJ_W-1:0]   pend_adj;
  logic signed [fwp_pkg::ADJ_W-1:0]   val;
  logic                              clip;

  assign pend_pos = !pend_len_i[fwp_pkg::LEN_W-1] && (|pend_len_i);
  assign sh = cfg_i.precomp_rows[pend_cls_i][fwp_pkg::SHIFT_W*class_i.cls +: fwp_pkg::SHIFT_W];
  assign sh_ext = {{(fwp_pkg::ADJ_W-fwp_pkg::SHIFT_W){sh[fwp_pkg::SHIFT_W-1]}}, sh};

  assign cur_base = $signed(fwp_pkg::ADJ_W'(frac_i) + fwp_pkg::ADJ_W'(class_i.write_time));
  assign cur_adj  = pend_pos ? cur_base + sh_ext : cur_base;
  assign pend_adj = {pend_len_i[fwp_pkg::LEN_W-1], pend_len_i} - sh_ext;

  always_comb begin
    clip = 1'b0;
    val  = pend_adj;
    if (pend_adj < fwp_pkg::LEN_MIN) begin
      val  = fwp_pkg::LEN_MIN;
      clip = 1'b1;
    end else if (pend_adj > fwp_pkg::LEN_MAX) begin
      val  = fwp_pkg::LEN_MAX;
      clip = 1'b1;
    end
  end

  assign pulse_o.valid         = pend_pos;
  assign pulse_o.counter_value = val[14:8];
  assign pulse_o.clipped       = clip;
  assign pulse_o.next_length   = cur_adj[fwp_pkg::LEN_W-1:0];

endmodule
`default_nettype wire

// ===== sv/flux_write_precompensation.sv =====
// Flux write precompensation. Each request on in_ch carries the bit-cell run
// count of one flux pulse; it is saturated to 127, classified against the
// configured class counts, and the class write time is added to a fractional
// accumulator. The previous pulse gets the signed shift from the class-pair
// table (previous class, current class), the same shift moves onto the current
// pulse, and the previous pulse is clamped to 0x300..0x7fff and sent on out_ch
// as its upper byte together with the clip flag, the invalid-pattern flag of
// the current pulse and the saturating invalid count. The first pulse after
// reset, or one whose pending length was driven to zero or below, yields no
// result. Rate: one request per cycle unless out_ch stalls; a result passes
// the input register, then the result register. The state loop (fraction
// accumulator, pending pulse, pending class, invalid count) closes through
// adds. Configuration is written through the APB port at byte address
// 8*index with 64-bit data; the user must write it only while the block is
// idle (not enforced by the block); no clearing pass is needed after reset.
// Depends on fwp_pkg, fwp_if, fwp_apb_regs, fwp_classify and fwp_precomp.
`default_nettype none
module flux_write_precompensation (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  fwp_in_if.sink                                in_ch,
  fwp_out_if.source                             out_ch,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fwp_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [fwp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [fwp_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready
);

  fwp_pkg::fwp_cfg_t   cfg;
  fwp_pkg::fwp_class_t class_info;
  fwp_pkg::fwp_pulse_t pulse;

  // Input register: saturated run count.
  logic                       s1_valid_q;
  logic [fwp_pkg::SAT_W-1:0]  run_q;
  logic                       s1_fire;

  // Pulse state carried from item to item.
  logic [fwp_pkg::FRAC_W-1:0]         frac_q;
  logic signed [fwp_pkg::LEN_W-1:0]   pend_len_q;
  logic [fwp_pkg::CLASS_W-1:0]        pend_cls_q;
  logic [fwp_pkg::INV_W-1:0]          inv_cnt_q;
  logic [fwp_pkg::INV_W-1:0]          inv_cnt_d;

  // Result register.
  logic                       out_valid_q;
  logic [fwp_pkg::CV_W-1:0]   cv_q;
  logic                       clip_q;
  logic                       pinv_q;
  logic [fwp_pkg::INV_W-1:0]  inv_total_q;

  fwp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fwp_classify u_classify (
    .cfg_i   (cfg),
    .run_i   (run_q),
    .class_o (class_info)
  );

  fwp_precomp u_precomp (
    .cfg_i      (cfg),
    .class_i    (class_info),
    .frac_i     (frac_q),
    .pend_len_i (pend_len_q),
    .pend_cls_i (pend_cls_q),
    .pulse_o    (pulse)
  );

  // Advance the input register whenever the result register can take a value;
  // a request that yields no result also needs a free slot, which keeps it simple.
  assign s1_fire     = s1_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !s1_valid_q || s1_fire;

  // Saturate the invalid count at all ones.
  always_comb begin
    inv_cnt_d = inv_cnt_q;
    if (!class_info.found && inv_cnt_q != fwp_pkg::INV_FULL) begin
      inv_cnt_d = inv_cnt_q + fwp_pkg::INV_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      run_q <= in_ch.run_count[fwp_pkg::RUN_W-1] ? fwp_pkg::RUN_SAT
                                                 : in_ch.run_count[fwp_pkg::SAT_W-1:0];
    end
  end

  // Pulse state: update once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q     <= '0;
      pend_len_q <= '0;
      pend_cls_q <= '0;
      inv_cnt_q  <= '0;
    end else if (s1_fire) begin
      frac_q     <= pulse.next_length[fwp_pkg::FRAC_W-1:0];
      pend_len_q <= pulse.next_length;
      pend_cls_q <= class_info.cls;
      inv_cnt_q  <= inv_cnt_d;
    end
  end

  // Result register: load on a result, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && pulse.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && pulse.valid) begin
      cv_q        <= pulse.counter_value;
      clip_q      <= pulse.clipped;
      pinv_q      <= !class_info.found;
      inv_total_q <= inv_cnt_d;
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.counter_value   = cv_q;
  assign out_ch.clipped         = clip_q;
  assign out_ch.pattern_invalid = pinv_q;
  assign out_ch.invalid_total   = inv_total_q;

endmodule
`default_nettype wire

// ===== tb/sv/flux_write_precompensation_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for flux_write_precompensation: random run-count streams
// with bursty requests and receiver stalls, predicted in-bench and compared per field.
// Depends on fwp_pkg, fwp_if and the block itself.
module flux_write_precompensation_tb;
  import fwp_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 7;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int REPORT_LIMIT   = 40;
  localparam int RANDOM_PHASES  = 14;
  localparam int INVALID_RUNS   = 100;   // long stretch of runs that match no class

  // One expected pulse on the result channel.
  typedef struct packed {
    logic [CV_W-1:0]  counter_value;
    logic             clipped;
    logic             pattern_invalid;
    logic [INV_W-1:0] invalid_total;
  } pulse_res_t;

  logic clk_i;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] reg_rdata;
  logic                  pready;

  fwp_in_if  in_ch ();
  fwp_out_if out_ch ();

  flux_write_precompensation DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (reg_rdata),
    .pready  (pready)
  );

  // Run counts waiting to be sent, and pulses waiting to come back.
  logic [RUN_W-1:0] pending_runs[$];
  pulse_res_t       expected_pulses[$];

  // Shadow of the register file and of the block's pulse state.
  fwp_cfg_t           shadow_cfg;
  logic [FRAC_W-1:0]  frac_acc;
  int                 pulse_len;
  logic [CLASS_W-1:0] pulse_cls;
  logic [INV_W-1:0]   invalid_cnt;

  int   mismatch_count = 0;
  int   quiet_cycles   = 0;
  logic run_taken      = 1'b0;

  // Sender burst state and receiver stall pattern.
  int          burst_left   = 0;
  int          gap_left     = 0;
  logic [15:0] stall_mask   = '1;
  int          stall_left   = 0;
  pulse_res_t  want;

  always #HALF_PERIOD clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: classify the saturated run, add its write time to the fraction,
  // then shift and clamp the pending pulse if one is waiting.
  // ---------------------------------------------------------------------------
  task automatic precompensate_run(input logic [RUN_W-1:0] run);
    int unsigned        ncls;
    logic [SAT_W-1:0]   sat;
    logic [CLASS_W-1:0] cls;
    logic               hit;
    int                 cur;
    int                 shift;
    int                 len;
    pulse_res_t         res;
    ncls = shadow_cfg.classes_in_use;
    if (ncls < 1) ncls = 1;
    if (ncls > MAX_CLASSES) ncls = MAX_CLASSES;
    sat = (run > RUN_SAT) ? RUN_SAT : run[SAT_W-1:0];
    hit = 1'b0;
    cls = '0;
    // The highest-numbered matching class wins.
    for (int c = 0; c < ncls; c++) begin
      if (shadow_cfg.class_counts[c*COUNT_W +: COUNT_W] == sat) begin
        cls = CLASS_W'(c);
        hit = 1'b1;
      end
    end
    // No match: count it as invalid and fall back on the last class in use.
    if (!hit) begin
      cls = CLASS_W'(ncls - 1);
      if (invalid_cnt != INV_FULL) invalid_cnt++;
    end
    cur = int'(frac_acc) + int'(shadow_cfg.class_write_times[cls*TIME_W +: TIME_W]);
    // A pending pulse exists only while its length is above zero.
    if (pulse_len > 0) begin
      shift = int'($signed(shadow_cfg.precomp_rows[pulse_cls][cls*SHIFT_W +: SHIFT_W]));
      pulse_len -= shift;
      cur       += shift;
      len = pulse_len;
      res.clipped = 1'b0;
      if (len < int'(LEN_MIN)) begin
        len = int'(LEN_MIN);
        res.clipped = 1'b1;
      end
      if (len > int'(LEN_MAX)) begin
        len = int'(LEN_MAX);
        res.clipped = 1'b1;
      end
      res.counter_value   = CV_W'(len >>> 8);
      res.pattern_invalid = !hit;
      res.invalid_total   = invalid_cnt;
      expected_pulses.push_back(res);
    end
    // Carry the whole sum as the new pending pulse, but only its low byte as fraction.
    pulse_len = cur;
    frac_acc  = cur[FRAC_W-1:0];
    pulse_cls = cls;
  endtask

  task automatic check_field(input string name, input logic [INV_W-1:0] exp_val,
                             input logic [INV_W-1:0] act_val);
    if (act_val !== exp_val) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge, check results against the
  // oldest expectation, predict from accepted requests, and run the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      run_taken = 1'b0;
    end else begin
      run_taken = in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pulses.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected result, expected none, actual cv=%0d clip=%0b inv=%0b tot=%0d",
                     $time, out_ch.counter_value, out_ch.clipped, out_ch.pattern_invalid,
                     out_ch.invalid_total);
        end else begin
          want = expected_pulses.pop_front();
          check_field("counter_value", INV_W'(want.counter_value), INV_W'(out_ch.counter_value));
          check_field("clipped", INV_W'(want.clipped), INV_W'(out_ch.clipped));
          check_field("pattern_invalid", INV_W'(want.pattern_invalid),
                      INV_W'(out_ch.pattern_invalid));
          check_field("invalid_total", want.invalid_total, out_ch.invalid_total);
        end
      end
      // Predict after checking; a result never leaves in the cycle its request enters.
      if (run_taken) precompensate_run(in_ch.run_count);
      if (run_taken || (out_ch.valid && out_ch.ready) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding, %0d runs unsent",
                 $time, expected_pulses.size(), pending_runs.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: send queued run counts in bursts of random length with random gaps.
  // Hold a request until the monitor has seen it taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !run_taken) begin
      // hold the current request
    end else if (gap_left > 0) begin
      gap_left--;
      in_ch.valid <= 1'b0;
    end else if (pending_runs.size() > 0) begin
      in_ch.valid     <= 1'b1;
      in_ch.run_count <= pending_runs.pop_front();
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 24);
        case ($urandom_range(0, 5))
          0, 1:    gap_left = 0;
          5:       gap_left = $urandom_range(5, 30);
          default: gap_left = $urandom_range(1, 4);
        endcase
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Receiver: rotate a stall mask, swapping in a new one every so often.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 4))
        0:       stall_mask = '1;
        1:       stall_mask = 16'h00ff;
        2:       stall_mask = 16'h0001;
        default: stall_mask = 16'($urandom) | 16'h0001;
      endcase
      stall_left = $urandom_range(16, 256);
    end
    stall_left--;
    out_ch.ready <= stall_mask[0];
    stall_mask = {stall_mask[0], stall_mask[15:1]};
  end

  // ---------------------------------------------------------------------------
  // Register access and phase control
  // ---------------------------------------------------------------------------
  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [APB_DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_CLASSES_IN_USE:    shadow_cfg.classes_in_use    = value[NCLS_W-1:0];
      REG_CLASS_COUNTS:      shadow_cfg.class_counts      = value[MAX_CLASSES*COUNT_W-1:0];
      REG_CLASS_WRITE_TIMES: shadow_cfg.class_write_times = value[MAX_CLASSES*TIME_W-1:0];
      REG_PRECOMP_ROW0:      shadow_cfg.precomp_rows[0]   = value;
      REG_PRECOMP_ROW1:      shadow_cfg.precomp_rows[1]   = value;
      REG_PRECOMP_ROW2:      shadow_cfg.precomp_rows[2]   = value;
      REG_PRECOMP_ROW3:      shadow_cfg.precomp_rows[3]   = value;
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every run is sent and every pulse is back, then let the
  // pipeline empty out runs that produce no pulse.
  task automatic wait_drained();
    while (pending_runs.size() != 0 || in_ch.valid || expected_pulses.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_setting(input fwp_cfg_t s);
    wait_drained();
    write_register(REG_CLASSES_IN_USE, APB_DATA_W'(s.classes_in_use));
    write_register(REG_CLASS_COUNTS, APB_DATA_W'(s.class_counts));
    write_register(REG_CLASS_WRITE_TIMES, APB_DATA_W'(s.class_write_times));
    write_register(REG_PRECOMP_ROW0, s.precomp_rows[0]);
    write_register(REG_PRECOMP_ROW1, s.precomp_rows[1]);
    write_register(REG_PRECOMP_ROW2, s.precomp_rows[2]);
    write_register(REG_PRECOMP_ROW3, s.precomp_rows[3]);
  endtask

  // Random setting: mostly sane class tables, with duplicates, extremes and
  // out-of-range class numbers mixed in.
  function automatic fwp_cfg_t random_setting();
    fwp_cfg_t           s;
    logic [TIME_W-1:0]  wt;
    logic [SHIFT_W-1:0] sh;
    s = '0;
    if ($urandom_range(0, 7) == 0)
      s.classes_in_use = NCLS_W'($urandom_range(0, 7));
    else
      s.classes_in_use = NCLS_W'($urandom_range(1, MAX_CLASSES));
    for (int c = 0; c < MAX_CLASSES; c++) begin
      case ($urandom_range(0, 9))
        0: s.class_counts[c*COUNT_W +: COUNT_W] = '0;
        1: s.class_counts[c*COUNT_W +: COUNT_W] = RUN_SAT;
        2: if (c > 0)
             s.class_counts[c*COUNT_W +: COUNT_W] = s.class_counts[(c-1)*COUNT_W +: COUNT_W];
        default: s.class_counts[c*COUNT_W +: COUNT_W] = COUNT_W'($urandom_range(0, 127));
      endcase
      case ($urandom_range(0, 9))
        0:       wt = '0;
        1:       wt = '1;
        2:       wt = TIME_W'($urandom_range(0, 'h400));
        default: wt = TIME_W'($urandom_range('h300, 'h7fff));
      endcase
      s.class_write_times[c*TIME_W +: TIME_W] = wt;
    end
    for (int r = 0; r < NROWS; r++) begin
      for (int c = 0; c < MAX_CLASSES; c++) begin
        case ($urandom_range(0, 15))
          0:       sh = 16'h8000;
          1:       sh = 16'h7fff;
          2:       sh = SHIFT_W'($urandom);
          3:       sh = '0;
          default: sh = SHIFT_W'($urandom_range(0, 'h200) - 'h100);
        endcase
        s.precomp_rows[r][c*SHIFT_W +: SHIFT_W] = sh;
      end
    end
    return s;
  endfunction

  // Pick a run count: mostly one that hits a configured class, else near
  // misses, saturating counts and noise.
  function automatic logic [RUN_W-1:0] pick_run();
    logic [COUNT_W-1:0] base;
    base = shadow_cfg.class_counts[$urandom_range(0, MAX_CLASSES-1)*COUNT_W +: COUNT_W];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        if (base == RUN_SAT && $urandom_range(0, 1) == 1)
          return RUN_W'($urandom_range(128, 255));
        return RUN_W'(base);
      end
      6:       return RUN_W'(base + 1);
      7:       return RUN_W'($urandom_range(128, 255));
      default: return RUN_W'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  fwp_cfg_t setting;

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.run_count = '0;
    out_ch.ready    = 1'b0;

    // Mirror the reset values of registers and state.
    shadow_cfg                = '0;
    shadow_cfg.classes_in_use = CLASSES_RESET;
    frac_acc                  = '0;
    pulse_len                 = 0;
    pulse_cls                 = '0;
    invalid_cnt               = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: all counts and times zero, so no pulse ever pends.
    pending_runs = '{8'd0, 8'd127, 8'd255};

    // Four classes, duplicated count (class 2 must win over class 1), a class
    // at the saturation count, and table entries at both shift extremes.
    setting.classes_in_use    = 3'd4;
    setting.class_counts      = {7'd127, 7'd5, 7'd5, 7'd0};
    setting.class_write_times = {15'h1234, 15'h0280, 15'h0000, 15'h7fff};
    setting.precomp_rows[0]   = {16'h7fff, 16'h8000, 16'h0010, 16'hfff0};
    setting.precomp_rows[1]   = '0;
    setting.precomp_rows[2]   = {16'h8000, 16'h0100, 16'hff00, 16'h7fff};
    setting.precomp_rows[3]   = {16'h0040, 16'hffc0, 16'h8000, 16'h7fff};
    load_setting(setting);
    pending_runs = '{8'd0, 8'd0, 8'd5, 8'd127, 8'd128, 8'd255, 8'd3,
                     8'd5, 8'd0, 8'd127, 8'd1, 8'h55, 8'haa, 8'd5};

    // Zero classes in use acts as one: a run of zero must not match class 1.
    setting.classes_in_use    = 3'd0;
    setting.class_counts      = {7'd0, 7'd0, 7'd0, 7'd10};
    setting.class_write_times = {15'h0, 15'h0, 15'h0, 15'h0900};
    setting.precomp_rows[0]   = 64'h0000_0000_0000_0123;
    setting.precomp_rows[1]   = '0;
    setting.precomp_rows[2]   = '0;
    setting.precomp_rows[3]   = '0;
    load_setting(setting);
    pending_runs = '{8'd10, 8'd0, 8'd10};

    // Seven classes in use acts as four; every register at all ones.
    setting.classes_in_use    = '1;
    setting.class_counts      = '1;
    setting.class_write_times = '1;
    setting.precomp_rows      = '1;
    load_setting(setting);
    pending_runs = '{8'd127, 8'd200, 8'd3, 8'd255};

    // Random settings with mostly well-formed run streams.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_setting(random_setting());
      repeat ($urandom_range(60, 140)) pending_runs.push_back(pick_run());
    end

    // A long stretch of invalid runs: only a run of zero matches.
    setting                   = '0;
    setting.classes_in_use    = 3'd1;
    setting.class_write_times = {15'h0, 15'h0, 15'h0, 15'h0a00};
    setting.precomp_rows[0]   = 64'h0000_0000_0000_fff8;
    load_setting(setting);
    repeat (INVALID_RUNS) pending_runs.push_back(RUN_W'($urandom_range(1, 255)));

    // Finish under a fresh random setting.
    load_setting(random_setting());
    repeat (120) pending_runs.push_back(pick_run());

    wait_drained();
    if (expected_pulses.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_pulses.size());
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== flux_write_precompensation.f =====
sv/fwp_pkg.sv
sv/fwp_if.sv
sv/fwp_apb_regs.sv
sv/fwp_classify.sv
sv/fwp_precomp.sv
sv/flux_write_precompensation.sv
tb/sv/flux_write_precompensation_tb.sv
